// ===== src/compact_integer_encoder_macros.svh =====
// assertion macros used by the serializer module (cie_back)
`ifndef COMPACT_INTEGER_ENCODER_MACROS_SVH
`define COMPACT_INTEGER_ENCODER_MACROS_SVH

// checked property, masked while reset is held
`define CIE_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// checked property that also covers the reset cycles
`define CIE_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

// ===== src/cie_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cie_pkg
// Shared types and constants of the compact integer encoder.
// ----------------------------------------------------------------------------
package cie_pkg;

    // field widths
    localparam int VALUE_W   = 64;
    localparam int BYTE_W    = 8;
    localparam int GROUP_W   = 7;
    localparam int LEN_W     = 3;

    // varint fits in fewer than 4 or 8 bytes below these bit counts
    localparam int VAR4_BITS = 21;
    localparam int VAR8_BITS = 49;

    // byte constants
    localparam logic [BYTE_W-1:0] VARINT_MASK = 8'h7F;
    localparam logic [BYTE_W-1:0] VARINT_MORE = 8'h80;
    localparam logic [BYTE_W-1:0] BYTE_MASK   = 8'hFF;

    // default depth of the job queue between front and back
    localparam int CIE_QUEUE_DEPTH = 4;

    // encoding form
    typedef enum logic [1:0] {
        CODE_FIXED8  = 2'd0,
        CODE_FIXED4  = 2'd1,
        CODE_VAR_POS = 2'd2,
        CODE_VAR_NEG = 2'd3
    } t_code;

    // one classified item waiting for serialization
    typedef struct packed {
        logic [VALUE_W-1:0] data;
        t_code              code;
        logic [LEN_W-1:0]   len_m1;
    } t_job;

endpackage

// ===== src/cie_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cie_front
// Classifies one value: picks the form, the payload word and the byte count.
// ----------------------------------------------------------------------------
module cie_front
    import cie_pkg::*;
(
    input  logic [VALUE_W-1:0] i_value,
    output t_job               o_job
);

    logic               w_lim4;
    logic [31:0]        w_neg32;
    logic [VALUE_W-1:0] w_neg64;
    logic               w_pos_fit;
    logic               w_neg_fit;
    logic [VALUE_W-1:0] w_pay;
    logic [LEN_W-1:0]   w_groups;

    // width class and the two negations
    assign w_lim4  = (i_value[63:32] == 32'd0);
    assign w_neg32 = 32'd0 - i_value[31:0];
    assign w_neg64 = {VALUE_W{1'b0}} - i_value;

    // does the short varint fit under the limit
    assign w_pos_fit = w_lim4 ? ((i_value >> VAR4_BITS) == '0)
                              : ((i_value >> VAR8_BITS) == '0);
    assign w_neg_fit = w_lim4 ? ((w_neg32 >> VAR4_BITS) == '0)
                              : ((w_neg64 >> VAR8_BITS) == '0);

    // payload word handed to the serializer
    always_comb begin
        if (w_pos_fit) begin
            w_pay = i_value;
        end else if (w_neg_fit) begin
            w_pay = w_lim4 ? {32'd0, w_neg32} : w_neg64;
        end else begin
            w_pay = i_value;
        end
    end

    // extra 7-bit groups beyond the first; payload stays below 2^49 here
    always_comb begin
        w_groups = '0;
        for (int k = 1; k < 7; k++) begin
            if ((w_pay >> (GROUP_W * k)) != '0) begin
                w_groups = w_groups + LEN_W'(1);
            end
        end
    end

    // assemble the job
    always_comb begin
        o_job.data = w_pay;
        if (w_pos_fit) begin
            o_job.code   = CODE_VAR_POS;
            o_job.len_m1 = w_groups;
        end else if (w_neg_fit) begin
            o_job.code   = CODE_VAR_NEG;
            o_job.len_m1 = w_groups;
        end else if (w_lim4) begin
            o_job.code   = CODE_FIXED4;
            o_job.len_m1 = LEN_W'(3);
        end else begin
            o_job.code   = CODE_FIXED8;
            o_job.len_m1 = LEN_W'(7);
        end
    end

endmodule

// ===== src/cie_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cie_fifo
// Small job queue that decouples the classifier from the serializer.
// ----------------------------------------------------------------------------
module cie_fifo
    import cie_pkg::*;
#(
    parameter int DEPTH = CIE_QUEUE_DEPTH
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_wr,
    input  t_job i_wdata,
    output logic o_full,
    input  logic i_rd,
    output t_job o_rdata,
    output logic o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    t_job        r_slots [DEPTH];
    logic [AW:0] r_wr_ptr;
    logic [AW:0] r_rd_ptr;
    logic [AW:0] n_wr_ptr;
    logic [AW:0] n_rd_ptr;
    logic        w_wr;
    logic        w_rd;

    // pointer compare with wrap bit
    assign o_empty = (r_wr_ptr == r_rd_ptr);
    assign o_full  = (r_wr_ptr[AW-1:0] == r_rd_ptr[AW-1:0]) &&
                     (r_wr_ptr[AW] != r_rd_ptr[AW]);
    assign w_wr    = i_wr && !o_full;
    assign w_rd    = i_rd && !o_empty;
    assign o_rdata = r_slots[r_rd_ptr[AW-1:0]];

    assign n_wr_ptr = w_wr ? r_wr_ptr + (AW+1)'(1) : r_wr_ptr;
    assign n_rd_ptr = w_rd ? r_rd_ptr + (AW+1)'(1) : r_rd_ptr;

    // pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
        end
    end

    // slot storage
    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_slots[r_wr_ptr[AW-1:0]] <= i_wdata;
        end
    end

endmodule

// ===== src/cie_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cie_back
// Serializer: turns one job into its bytes and sends them into an output
// register, one per cycle while that register is free.
// ----------------------------------------------------------------------------
`include "compact_integer_encoder_macros.svh"

module cie_back
    import cie_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_job              i_job,
    input  logic              i_empty,
    output logic              o_rd,
    input  logic              i_pop,
    output logic              o_valid,
    output logic [BYTE_W-1:0] o_byte,
    output logic [1:0]        o_code,
    output logic              o_last
);

    logic               r_busy;
    logic [VALUE_W-1:0] r_data;
    t_code              r_code;
    logic [LEN_W-1:0]   r_left;
    logic               r_out_valid;
    logic [BYTE_W-1:0]  r_out_byte;
    t_code              r_out_code;
    logic               r_out_last;

    logic               n_busy;
    logic               n_out_valid;
    logic               w_adv;
    logic               w_load;
    logic               w_fixed;
    logic               w_final;
    logic [BYTE_W-1:0]  w_byte;
    logic [VALUE_W-1:0] w_shift;

    // output register frees up when empty or taken this cycle
    assign w_adv   = !r_out_valid || i_pop;
    assign w_final = (r_left == '0);
    assign w_load  = !i_empty && (!r_busy || (w_adv && w_final));
    assign o_rd    = w_load;

    // current byte and the remaining payload
    assign w_fixed = (r_code == CODE_FIXED8) || (r_code == CODE_FIXED4);
    always_comb begin
        if (w_fixed) begin
            w_byte  = r_data[BYTE_W-1:0] & BYTE_MASK;
            w_shift = r_data >> BYTE_W;
        end else begin
            w_byte  = (r_data[BYTE_W-1:0] & VARINT_MASK) |
                      (w_final ? '0 : VARINT_MORE);
            w_shift = r_data >> GROUP_W;
        end
    end

    // control next state
    always_comb begin
        n_out_valid = w_adv ? r_busy : r_out_valid;
        if (w_load) begin
            n_busy = 1'b1;
        end else if (w_adv && r_busy && w_final) begin
            n_busy = 1'b0;
        end else begin
            n_busy = r_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_busy      <= n_busy;
            r_out_valid <= n_out_valid;
        end
    end

    // job payload
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_data <= i_job.data;
            r_code <= i_job.code;
            r_left <= i_job.len_m1;
        end else if (w_adv && r_busy) begin
            r_data <= w_shift;
            r_left <= r_left - LEN_W'(1);
        end
    end

    // output register payload
    always_ff @(posedge i_clk) begin
        if (w_adv && r_busy) begin
            r_out_byte <= w_byte;
            r_out_code <= r_code;
            r_out_last <= w_final;
        end
    end

    assign o_valid = r_out_valid;
    assign o_byte  = r_out_byte;
    assign o_code  = r_out_code;
    assign o_last  = r_out_last;

    // checks
    `CIE_ASSERT_RST(a_reset_clears_out, !i_rst_n |=> !r_out_valid, "output valid after reset")
    `CIE_ASSERT(a_fixed4_len, (w_load && i_job.code == CODE_FIXED4) |-> (i_job.len_m1 == LEN_W'(3)), "fixed4 job not 4 bytes")
    `CIE_ASSERT(a_varint_cont, (r_out_valid && (r_out_code == CODE_VAR_POS || r_out_code == CODE_VAR_NEG)) |-> (r_out_byte[7] == !r_out_last), "varint continuation bit wrong")
    `CIE_ASSERT(a_job_done, (r_busy && w_final && w_adv && !w_load) |=> !r_busy, "serializer did not retire job")

endmodule

// ===== src/compact_integer_encoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// compact_integer_encoder
// Encodes a 64-bit value as a short run of tagged bytes (varint, negated
// varint or fixed little-endian).
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: drive i_value and raise push; the item is taken at a clock
//   edge where push is high and full is low.
//   Result channel: while empty is low, o_out_byte, o_type_code and o_last
//   show the oldest byte; it is taken at an edge where pop is high.
//   Each item yields 1 to 8 bytes; o_last marks its final byte and
//   o_type_code is the same on every byte of one item.
//   Path: an item passes through the job queue and the serializer's job
//   register before its first byte reaches the output register.
//   Throughput: one byte per cycle while the output register is free; an
//   item holds the serializer until its 1 to 8 bytes are sent, and the job
//   queue lets new items be classified while earlier ones are still being sent.
//   When the receiver stalls, the output register holds, the serializer
//   waits, the queue fills and full rises.
//   Reset (synchronous, active low) empties the queue and the output.
// ----------------------------------------------------------------------------
module compact_integer_encoder
    import cie_pkg::*;
#(
    parameter int QUEUE_DEPTH = CIE_QUEUE_DEPTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  logic [VALUE_W-1:0] i_value,
    output logic               empty,
    input  logic               pop,
    output logic [BYTE_W-1:0]  o_out_byte,
    output logic [1:0]         o_type_code,
    output logic               o_last
);

    t_job w_front_job;
    t_job w_queue_job;
    logic w_queue_empty;
    logic w_queue_rd;
    logic w_out_valid;

    // classifier
    cie_front u_front (
        .i_value (i_value),
        .o_job   (w_front_job)
    );

    // job queue
    cie_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (push),
        .i_wdata (w_front_job),
        .o_full  (full),
        .i_rd    (w_queue_rd),
        .o_rdata (w_queue_job),
        .o_empty (w_queue_empty)
    );

    // serializer
    cie_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_job   (w_queue_job),
        .i_empty (w_queue_empty),
        .o_rd    (w_queue_rd),
        .i_pop   (pop),
        .o_valid (w_out_valid),
        .o_byte  (o_out_byte),
        .o_code  (o_type_code),
        .o_last  (o_last)
    );

    assign empty = !w_out_valid;

endmodule
